[sv/mfbp_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the MSB-first bit packer: function codes, sequencer
// states, default sizes and the structs passed between its modules.
// No dependencies.
package mfbp_pkg;

    localparam int MAX_FIELD_WIDTH_DEF = 64;
    localparam int BITS_PER_BYTE       = 8;
    localparam logic [7:0] PACKET_SIZE_RESET = 8'd188;
    localparam logic [7:0] COUNT_MAX         = 8'd255;

    typedef enum logic [1:0] {
        FUNC_WRITE_BITS = 2'd0,
        FUNC_RAW_BYTE   = 2'd1,
        FUNC_FLUSH      = 2'd2,
        FUNC_RESTART    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_ALIGN  = 2'd1,
        ST_PACK   = 2'd2,
        ST_SINGLE = 2'd3
    } state_t;

    // Result of one step of the shared pack unit
    typedef struct packed {
        logic       emit;
        logic       last;
        logic [7:0] byte_val;
        logic [7:0] pending_next;
        logic [2:0] bit_count_next;
    } pack_step_t;

    // One byte headed for the output register
    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       overflow;
    } beat_t;

endpackage

[sv/msb_first_bit_packer.sv]
`timescale 1ns / 1ps
// Top level of the MSB-first bit packer. Uses mfbp_pkg, mfbp_pack_unit and
// mfbp_out_reg.
//
// Packs fields of 1 to MAX_FIELD_WIDTH bits, most significant bit first, into
// a byte stream; each byte comes out with last_of_run (final byte caused by
// this input transaction) and overflow (packet byte count including this byte
// exceeds packet_size). func selects write bits, write raw byte, flush
// (pending bits left-aligned, zero-padded) or restart (drop pending bits and
// clear the packet count). Widths above MAX_FIELD_WIDTH are clamped; width
// zero writes nothing. One transaction at a time: in_ready is high only when
// the sequencer is idle. A bit write holds the input through an alignment
// step, one byte step per full byte formed from the pending and new bits and
// a merge step; a raw byte or flush holds it through the single-byte state
// after acceptance; a restart or empty flush completes at acceptance. The
// single shared shift/merge unit cuts one byte per cycle while the output
// register has a free slot, and stalls while it waits on out_ready.
// cfg_data writes packet_size (reset 188) and is always ready; write it only
// while idle.
module msb_first_bit_packer #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [6:0]  bit_width,
    input  logic [63:0] field_value,
    input  logic [7:0]  raw_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic        last_of_run,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int RW = $clog2(MAX_FIELD_WIDTH + 1);

    mfbp_pkg::state_t state_reg, state_next;

    logic [7:0]                 pending_reg, pending_next;
    logic [2:0]                 bit_count_reg, bit_count_next;
    logic [7:0]                 pkt_count_reg, pkt_count_next;
    logic [7:0]                 packet_size_reg;
    logic [MAX_FIELD_WIDTH-1:0] aligned_reg, aligned_next;
    logic [RW-1:0]              remaining_reg, remaining_next;
    logic [7:0]                 hold_byte_reg, hold_byte_next;

    logic                       in_fire;
    logic                       slot_free;
    logic                       beat_load;
    mfbp_pkg::beat_t            beat;

    logic [MAX_FIELD_WIDTH-1:0] unit_aligned_next;
    logic [RW-1:0]              unit_remaining_next;
    mfbp_pkg::pack_step_t       step;

    logic                       cur_overflow;
    logic [7:0]                 pkt_count_inc;

    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // The packet count saturates, so 255 always compares as over the limit
    assign cur_overflow  = (pkt_count_reg >= packet_size_reg);
    assign pkt_count_inc = (pkt_count_reg == mfbp_pkg::COUNT_MAX) ? pkt_count_reg
                                                                  : pkt_count_reg + 8'd1;

    mfbp_pack_unit #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .RW              (RW)
    ) u_pack_unit (
        .align_mode     (state_reg == mfbp_pkg::ST_ALIGN),
        .aligned        (aligned_reg),
        .remaining      (remaining_reg),
        .pending        (pending_reg),
        .bit_count      (bit_count_reg),
        .aligned_next   (unit_aligned_next),
        .remaining_next (unit_remaining_next),
        .step           (step)
    );

    mfbp_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (beat_load),
        .beat        (beat),
        .slot_free   (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_out    (byte_out),
        .last_of_run (last_of_run),
        .overflow    (overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mfbp_pkg::ST_IDLE;
            pending_reg     <= 8'd0;
            bit_count_reg   <= 3'd0;
            pkt_count_reg   <= 8'd0;
            packet_size_reg <= mfbp_pkg::PACKET_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            bit_count_reg <= bit_count_next;
            pkt_count_reg <= pkt_count_next;
            if (cfg_valid && cfg_ready)
            begin
                packet_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        aligned_reg   <= aligned_next;
        remaining_reg <= remaining_next;
        hold_byte_reg <= hold_byte_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        bit_count_next = bit_count_reg;
        pkt_count_next = pkt_count_reg;
        aligned_next   = aligned_reg;
        remaining_next = remaining_reg;
        hold_byte_next = hold_byte_reg;
        in_ready       = 1'b0;
        beat_load      = 1'b0;
        beat.byte_val  = step.byte_val;
        beat.last      = step.last;
        beat.overflow  = cur_overflow;

        unique case (state_reg)
            mfbp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (func)
                        mfbp_pkg::FUNC_WRITE_BITS:
                        begin
                            // Clamp oversize widths, then left-align next cycle
                            aligned_next = field_value[MAX_FIELD_WIDTH-1:0];
                            if (bit_width > 7'(MAX_FIELD_WIDTH))
                            begin
                                remaining_next = RW'(MAX_FIELD_WIDTH);
                            end
                            else
                            begin
                                remaining_next = RW'(bit_width);
                            end
                            state_next = mfbp_pkg::ST_ALIGN;
                        end
                        mfbp_pkg::FUNC_RAW_BYTE:
                        begin
                            hold_byte_next = raw_byte;
                            state_next     = mfbp_pkg::ST_SINGLE;
                        end
                        mfbp_pkg::FUNC_FLUSH:
                        begin
                            if (bit_count_reg != 3'd0)
                            begin
                                hold_byte_next = 8'(pending_reg << (4'd8 - {1'b0, bit_count_reg}));
                                pending_next   = 8'd0;
                                bit_count_next = 3'd0;
                                state_next     = mfbp_pkg::ST_SINGLE;
                            end
                        end
                        mfbp_pkg::FUNC_RESTART:
                        begin
                            pending_next   = 8'd0;
                            bit_count_next = 3'd0;
                            pkt_count_next = 8'd0;
                        end
                        default:
                        begin
                            state_next = mfbp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mfbp_pkg::ST_ALIGN:
            begin
                aligned_next = unit_aligned_next;
                state_next   = mfbp_pkg::ST_PACK;
            end
            mfbp_pkg::ST_PACK:
            begin
                if (step.emit)
                begin
                    // Full byte available: advance only when the output slot is free
                    if (slot_free)
                    begin
                        beat_load      = 1'b1;
                        pkt_count_next = pkt_count_inc;
                        pending_next   = 8'd0;
                        bit_count_next = 3'd0;
                        aligned_next   = unit_aligned_next;
                        remaining_next = unit_remaining_next;
                    end
                end
                else
                begin
                    // Fewer than eight bits left: fold them in and finish
                    pending_next   = step.pending_next;
                    bit_count_next = step.bit_count_next;
                    state_next     = mfbp_pkg::ST_IDLE;
                end
            end
            mfbp_pkg::ST_SINGLE:
            begin
                beat.byte_val = hold_byte_reg;
                beat.last     = 1'b1;
                if (slot_free)
                begin
                    beat_load      = 1'b1;
                    pkt_count_next = pkt_count_inc;
                    state_next     = mfbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfbp_pkg::ST_IDLE;
            end
        endcase
    end

    // Bytes come only from the pack loop or the single-byte state
    assert property (@(posedge clk) disable iff (!rst_n)
        beat_load |-> (state_reg == mfbp_pkg::ST_PACK || state_reg == mfbp_pkg::ST_SINGLE))
        else $error("byte loaded outside an emitting state");

    // A byte cut from a bit write leaves nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (beat_load && state_reg == mfbp_pkg::ST_PACK) |=> bit_count_reg == 3'd0)
        else $error("pending bits survive an emitted byte");

    // Restart clears the packet count
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == mfbp_pkg::FUNC_RESTART) |=> pkt_count_reg == 8'd0)
        else $error("restart did not clear packet count");

    // Packet count only grows outside a restart
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && func == mfbp_pkg::FUNC_RESTART) |=> pkt_count_reg >= $past(pkt_count_reg))
        else $error("packet count went backwards");

    // Alignment always hands over to the pack loop
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mfbp_pkg::ST_ALIGN |=> state_reg == mfbp_pkg::ST_PACK)
        else $error("alignment did not enter pack loop");

endmodule

[sv/mfbp_pack_unit.sv]
`timescale 1ns / 1ps
// Shared shift/merge unit of the bit packer: left-aligns a field, then cuts
// one byte per step from the field and the pending partial byte.
// Depends on mfbp_pkg.
module mfbp_pack_unit #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::MAX_FIELD_WIDTH_DEF,
    parameter int RW = $clog2(MAX_FIELD_WIDTH + 1)
) (
    input  logic                       align_mode,
    input  logic [MAX_FIELD_WIDTH-1:0] aligned,
    input  logic [RW-1:0]              remaining,
    input  logic [7:0]                 pending,
    input  logic [2:0]                 bit_count,
    output logic [MAX_FIELD_WIDTH-1:0] aligned_next,
    output logic [RW-1:0]              remaining_next,
    output mfbp_pkg::pack_step_t       step
);

    localparam logic [RW-1:0] W_VAL    = RW'(MAX_FIELD_WIDTH);
    localparam logic [RW:0]   BYTE_SUM = (RW + 1)'(mfbp_pkg::BITS_PER_BYTE);

    logic [7:0] top8;
    logic [3:0] take;
    logic [3:0] merge_shift;
    logic [RW:0] total;

    assign top8        = aligned[MAX_FIELD_WIDTH-1 -: 8];
    assign take        = 4'd8 - {1'b0, bit_count};
    assign merge_shift = 4'd8 - {1'b0, remaining[2:0]};
    assign total       = {1'b0, remaining} + (RW + 1)'(bit_count);

    always_comb
    begin
        step.emit      = (total >= BYTE_SUM);
        step.byte_val  = 8'(pending << take) | 8'(top8 >> bit_count);
        remaining_next = remaining - RW'(take);
        step.last      = (remaining_next < RW'(8));
        if (align_mode)
        begin
            aligned_next = aligned << (W_VAL - remaining);
        end
        else
        begin
            aligned_next = aligned << take;
        end
        // Partial step: fold the leftover bits into the pending byte
        step.pending_next   = 8'(pending << remaining[2:0]) | 8'(top8 >> merge_shift);
        step.bit_count_next = bit_count + remaining[2:0];
    end

endmodule

[sv/mfbp_out_reg.sv]
`timescale 1ns / 1ps
// Output holding register of the bit packer: keeps one byte transaction
// until the consumer takes it. Depends on mfbp_pkg.
module mfbp_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  mfbp_pkg::beat_t beat,
    output logic            slot_free,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      byte_out,
    output logic            last_of_run,
    output logic            overflow
);

    logic            valid_reg;
    mfbp_pkg::beat_t beat_reg;

    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && load)
        begin
            beat_reg <= beat;
        end
    end

    assign out_valid   = valid_reg;
    assign byte_out    = beat_reg.byte_val;
    assign last_of_run = beat_reg.last;
    assign overflow    = beat_reg.overflow;

endmodule
